// ===== design/pdt_pkg.sv =====
// shared constants, types and codes for the pairwise distance table
package pdt_pkg;

  localparam int FUNC_W     = 2;
  localparam int IDX_IN_W   = 6;
  localparam int COORD_W    = 10;
  localparam int DIST_W     = 28;
  localparam int FRAC_SHIFT = 8;

  localparam int NUM_POINTS_DEF = 64;
  localparam int COORD_MAX_DEF  = 1023;

  // dx^2 + dy^2 of two coordinates
  localparam int SUMSQ_W = 2 * COORD_W + 1;
  // root of the sum shifted up by two fraction fields
  localparam int ROOT_W  = (SUMSQ_W + 2 * FRAC_SHIFT + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;

  localparam logic [DIST_W-1:0] DIAG_Q8 = DIST_W'(999999 << FRAC_SHIFT);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE      = 2'd0,
    FUNC_REBUILD    = 2'd1,
    FUNC_READ_DIST  = 2'd2,
    FUNC_READ_POINT = 2'd3
  } func_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } dist_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } dist_rsp_t;

endpackage

// ===== design/pairwise_distance_table.sv =====
// top level: point store, distance table and the rebuild sequencer
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in      | input     | in_valid, in_stall | func, index_a, index_b, coord_x, coord_y
//   out     | output    | out_valid,out_stall| distance_q8, point_x_out, point_y_out
//
// one beat at a time: write point goes to S_DONE, read point passes S_PREAD, read distance
//   passes S_DADDR and S_DREAD; rebuild walks each pair through S_RDI, S_RDJ and S_CAPJ,
//   plus S_WAIT on the 19-step square root in the distance unit for an off-diagonal pair
// reset: no clearing pass; the table reads as zero until the first rebuild has finished
// a stalled output holds its beat while the block already takes the next input beat
module pairwise_distance_table #(
  parameter int NUM_POINTS = pdt_pkg::NUM_POINTS_DEF,
  parameter int COORD_MAX  = pdt_pkg::COORD_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pdt_pkg::FUNC_W-1:0]   func,
  input  logic [pdt_pkg::IDX_IN_W-1:0] index_a,
  input  logic [pdt_pkg::IDX_IN_W-1:0] index_b,
  input  logic [pdt_pkg::COORD_W-1:0]  coord_x,
  input  logic [pdt_pkg::COORD_W-1:0]  coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pdt_pkg::DIST_W-1:0]   distance_q8,
  output logic [pdt_pkg::COORD_W-1:0]  point_x_out,
  output logic [pdt_pkg::COORD_W-1:0]  point_y_out
);
  import pdt_pkg::*;

  localparam int IDX_W = $clog2(NUM_POINTS);
  localparam int DA_W  = $clog2(NUM_POINTS * NUM_POINTS);
  localparam int PT_W  = 2 * COORD_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREAD = 9'b000000010,
    S_DADDR = 9'b000000100,
    S_DREAD = 9'b000001000,
    S_RDI   = 9'b000010000,
    S_RDJ   = 9'b000100000,
    S_CAPJ  = 9'b001000000,
    S_WAIT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic                accept;
  logic                out_free;
  logic                in_ia_ok;
  logic                ia_ok;
  logic                ib_ok;
  logic                built;
  logic [IDX_IN_W-1:0] ia_q;
  logic [IDX_IN_W-1:0] ib_q;
  logic [IDX_W-1:0]    row;
  logic [IDX_W-1:0]    col;
  logic [DA_W-1:0]     waddr;
  logic                row_last;
  logic                col_last;
  logic                last_pair;
  logic                diag;
  logic                pair_wr;
  logic [COORD_W-1:0]  cx_sat;
  logic [COORD_W-1:0]  cy_sat;
  logic [COORD_W-1:0]  pi_x;
  logic [COORD_W-1:0]  pi_y;
  logic [COORD_W-1:0]  pj_x;
  logic [COORD_W-1:0]  pj_y;
  logic                pt_we;
  logic [IDX_W-1:0]    pt_raddr;
  logic [PT_W-1:0]     pt_rdata;
  logic                d_we;
  logic [DIST_W-1:0]   d_wdata;
  logic [DA_W-1:0]     d_raddr;
  logic [DIST_W-1:0]   d_rdata;
  logic [DIST_W-1:0]   res_dist;
  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  dist_req_t           req;
  dist_rsp_t           rsp;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign in_ia_ok = (int'(index_a) < NUM_POINTS);
  assign ia_ok    = (int'(ia_q) < NUM_POINTS);
  assign ib_ok    = (int'(ib_q) < NUM_POINTS);

  assign cx_sat = (int'(coord_x) > COORD_MAX) ? COORD_W'(COORD_MAX) : coord_x;
  assign cy_sat = (int'(coord_y) > COORD_MAX) ? COORD_W'(COORD_MAX) : coord_y;

  assign row_last  = (int'(row) == NUM_POINTS - 1);
  assign col_last  = (int'(col) == NUM_POINTS - 1);
  assign last_pair = row_last && col_last;
  assign diag      = (row == col);

  assign pj_x = pt_rdata[PT_W-1:COORD_W];
  assign pj_y = pt_rdata[COORD_W-1:0];

  assign req.start = (state == S_CAPJ) && !diag;
  assign req.dx    = (pi_x > pj_x) ? pi_x - pj_x : pj_x - pi_x;
  assign req.dy    = (pi_y > pj_y) ? pi_y - pj_y : pj_y - pi_y;

  assign pair_wr = ((state == S_CAPJ) && diag) || ((state == S_WAIT) && rsp.done);
  assign d_we    = pair_wr;
  assign d_wdata = diag ? DIAG_Q8 : DIST_W'(rsp.root);
  assign d_raddr = DA_W'(int'(ia_q) * NUM_POINTS + int'(ib_q));

  assign pt_we = accept && (func_t'(func) == FUNC_WRITE) && in_ia_ok;

  always_comb begin
    unique case (state)
      S_RDI:   pt_raddr = row;
      S_RDJ:   pt_raddr = col;
      default: pt_raddr = IDX_W'(index_a);
    endcase
  end

  pdt_ram #(
    .WIDTH (PT_W),
    .DEPTH (NUM_POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (IDX_W'(index_a)),
    .wdata ({cx_sat, cy_sat}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  pdt_ram #(
    .WIDTH (DIST_W),
    .DEPTH (NUM_POINTS * NUM_POINTS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  pdt_dist_unit u_dist_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(func))
            FUNC_WRITE:      state_next = S_DONE;
            FUNC_REBUILD:    state_next = S_RDI;
            FUNC_READ_DIST:  state_next = S_DADDR;
            FUNC_READ_POINT: state_next = S_PREAD;
            default:         state_next = S_DONE;
          endcase
        end
      end
      S_PREAD: state_next = S_DONE;
      S_DADDR: state_next = S_DREAD;
      S_DREAD: state_next = S_DONE;
      S_RDI:   state_next = S_RDJ;
      S_RDJ:   state_next = S_CAPJ;
      S_CAPJ: begin
        if (diag) begin
          state_next = last_pair ? S_DONE : S_RDI;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rsp.done) begin
          state_next = last_pair ? S_DONE : S_RDI;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control: state, pair walk, table-built flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      built     <= 1'b0;
      row       <= '0;
      col       <= '0;
      waddr     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        row   <= '0;
        col   <= '0;
        waddr <= '0;
      end else if (pair_wr) begin
        waddr <= waddr + DA_W'(1);
        if (col_last) begin
          col <= '0;
          if (row_last) begin
            built <= 1'b1;
          end else begin
            row <= row + IDX_W'(1);
          end
        end else begin
          col <= col + IDX_W'(1);
        end
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ia_q     <= index_a;
      ib_q     <= index_b;
      res_dist <= '0;
      res_x    <= '0;
      res_y    <= '0;
    end
    if ((state == S_PREAD) && ia_ok) begin
      res_x <= pj_x;
      res_y <= pj_y;
    end
    // unbuilt table reads as zero
    if ((state == S_DREAD) && ia_ok && ib_ok && built) begin
      res_dist <= d_rdata;
    end
    if (state == S_RDJ) begin
      pi_x <= pj_x;
      pi_y <= pj_y;
    end
    if ((state == S_DONE) && out_free) begin
      distance_q8 <= res_dist;
      point_x_out <= res_x;
      point_y_out <= res_y;
    end
  end

endmodule

// ===== design/pdt_ram.sv =====
// generic single write port ram with registered read
module pdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pdt_dist_unit.sv =====
// shared distance unit: one squarer used twice, then a bit-per-cycle square root
module pdt_dist_unit (
  input  logic               clk,
  input  logic               rst,
  input  pdt_pkg::dist_req_t req,
  output pdt_pkg::dist_rsp_t rsp
);
  import pdt_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_SQX  = 4'b0010,
    U_SQY  = 4'b0100,
    U_ROOT = 4'b1000
  } ustate_t;

  ustate_t                state;
  logic [COORD_W-1:0]     dx_q;
  logic [COORD_W-1:0]     dy_q;
  logic [COORD_W-1:0]     mul_op;
  logic [2*COORD_W-1:0]   prod;
  logic [SUMSQ_W-1:0]     acc;
  logic [RAD_W-1:0]       rad;
  logic [REM_W-1:0]       rem;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;
  logic [REM_W-1:0]       rem_sub;
  logic [ROOT_W-1:0]      root;
  logic [CNT_W-1:0]       cnt;
  logic                   ge;
  logic                   last;
  logic                   done;

  assign mul_op  = (state == U_SQY) ? dy_q : dx_q;
  assign prod    = (2 * COORD_W)'(mul_op) * (2 * COORD_W)'(mul_op);

  // remainder never needs more than ROOT_W bits before the shift
  assign rem_sh  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial   = {root, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;
  assign last    = (cnt == CNT_W'(ROOT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (req.start) begin
            state <= U_SQX;
          end
        end
        U_SQX: begin
          state <= U_SQY;
        end
        U_SQY: begin
          state <= U_ROOT;
        end
        U_ROOT: begin
          if (last) begin
            state <= U_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        if (req.start) begin
          dx_q <= req.dx;
          dy_q <= req.dy;
        end
      end
      U_SQX: begin
        acc <= SUMSQ_W'(prod);
      end
      U_SQY: begin
        rad  <= RAD_W'({SUMSQ_W'(acc + SUMSQ_W'(prod)), (2 * FRAC_SHIFT)'(0)});
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      U_ROOT: begin
        rad  <= rad << 2;
        rem  <= ge ? rem_sub : rem_sh;
        root <= {root[ROOT_W-2:0], ge};
        cnt  <= cnt + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

// ===== design/pdt_checker.sv =====
// port-level checks for the pairwise distance table, bound to the top level
module pdt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pdt_pkg::DIST_W-1:0]   distance_q8,
  input logic [pdt_pkg::COORD_W-1:0]  point_x_out,
  input logic [pdt_pkg::COORD_W-1:0]  point_y_out
);
  import pdt_pkg::*;

  // a stalled output beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_q8)
      && $stable(point_x_out) && $stable(point_y_out))
    else $error("output beat changed while stalled");

  // only one item in flight: the beat after an accept is stalled
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is still in work");

  // a result carries either a distance or a point, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_q8 == '0) || ((point_x_out == '0) && (point_y_out == '0)))
    else $error("result mixes distance and point fields");

  // no table entry exceeds the diagonal marker
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_q8 <= DIAG_Q8))
    else $error("distance above diagonal value");

endmodule

bind pairwise_distance_table pdt_checker u_pdt_checker (.*);

// ===== sim/tb_top.sv =====
// self-checking testbench for the pairwise distance table
`timescale 1ns / 1ps
module tb_top;
  import pdt_pkg::*;

  localparam int NPTS          = NUM_POINTS_DEF;
  localparam int LIMIT_CYCLES  = 3000000;
  localparam int RANDOM_ITEMS  = 1870;
  localparam int QUIET_TAIL    = 150;
  localparam int REBUILD_EVERY = 400;
  localparam int DRAIN_CYCLES  = 20;
  localparam logic [COORD_W-1:0] CMAX = COORD_W'(COORD_MAX_DEF);

  typedef struct packed {
    func_t               op;
    logic [IDX_IN_W-1:0] ia;
    logic [IDX_IN_W-1:0] ib;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } beat_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  typed;
    beat_t want;
  } step_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   func;
  logic [IDX_IN_W-1:0] index_a;
  logic [IDX_IN_W-1:0] index_b;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;
  logic                out_valid;
  logic                out_stall;
  logic [DIST_W-1:0]   distance_q8;
  logic [COORD_W-1:0]  point_x_out;
  logic [COORD_W-1:0]  point_y_out;

  // predictor state
  logic [COORD_W-1:0] pt_x [NPTS];
  logic [COORD_W-1:0] pt_y [NPTS];
  logic [DIST_W-1:0]  dist_snapshot [NPTS*NPTS];

  beat_t expected_beats [$];
  step_t directed_steps [$];
  int    fail_count = 0;
  bit    quiet = 1'b0;

  pairwise_distance_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .index_a     (index_a),
    .index_b     (index_b),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .distance_q8 (distance_q8),
    .point_x_out (point_x_out),
    .point_y_out (point_y_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // bit-by-bit search for the largest root whose square fits
  function automatic logic [DIST_W-1:0] isqrt_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return DIST_W'(r);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] c);
    return (c > CMAX) ? CMAX : c;
  endfunction

  function automatic void rebuild_snapshot();
    longint unsigned dx;
    longint unsigned dy;
    for (int i = 0; i < NPTS; i++) begin
      for (int j = 0; j < NPTS; j++) begin
        if (i == j) begin
          dist_snapshot[i*NPTS + j] = DIAG_Q8;
        end else begin
          dx = (pt_x[i] > pt_x[j]) ? pt_x[i] - pt_x[j] : pt_x[j] - pt_x[i];
          dy = (pt_y[i] > pt_y[j]) ? pt_y[i] - pt_y[j] : pt_y[j] - pt_y[i];
          dist_snapshot[i*NPTS + j] = isqrt_floor((dx*dx + dy*dy) << (2*FRAC_SHIFT));
        end
      end
    end
  endfunction

  function automatic beat_t apply_command(cmd_t c);
    beat_t r;
    r = '0;
    case (c.op)
      FUNC_WRITE: begin
        if (c.ia < NPTS) begin
          pt_x[c.ia] = clamp_coord(c.cx);
          pt_y[c.ia] = clamp_coord(c.cy);
        end
      end
      FUNC_REBUILD: begin
        rebuild_snapshot();
      end
      FUNC_READ_DIST: begin
        if (c.ia < NPTS && c.ib < NPTS) r.distance = dist_snapshot[c.ia*NPTS + c.ib];
      end
      default: begin
        if (c.ia < NPTS) begin
          r.x = pt_x[c.ia];
          r.y = pt_y[c.ia];
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_step(func_t op, int ia, int ib, int cx, int cy,
                                   bit typed, int d, int x, int y);
    step_t s;
    s.cmd.op        = op;
    s.cmd.ia        = IDX_IN_W'(ia);
    s.cmd.ib        = IDX_IN_W'(ib);
    s.cmd.cx        = COORD_W'(cx);
    s.cmd.cy        = COORD_W'(cy);
    s.typed         = typed;
    s.want.distance = DIST_W'(d);
    s.want.x        = COORD_W'(x);
    s.want.y        = COORD_W'(y);
    directed_steps.push_back(s);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int seg);
    int r;
    r = $urandom_range(0, 99);
    case (seg % 4)
      1: return COORD_W'($urandom_range(0, 3));
      3: return (r < 50) ? '0 : CMAX;
      default: begin
        if (r < 15) return '0;
        else if (r < 30) return CMAX;
        else return COORD_W'($urandom);
      end
    endcase
  endfunction

  // mostly reads and writes, a rebuild at the end of each segment
  function automatic cmd_t random_cmd(int k);
    cmd_t c;
    int   seg;
    int   r;
    seg  = k / REBUILD_EVERY;
    r    = $urandom_range(0, 99);
    c.ia = IDX_IN_W'($urandom_range(0, NPTS - 1));
    c.ib = IDX_IN_W'($urandom);
    c.cx = pick_coord(seg);
    c.cy = pick_coord(seg);
    if (k % REBUILD_EVERY == REBUILD_EVERY - 1) c.op = FUNC_REBUILD;
    else if (r < 30) c.op = FUNC_WRITE;
    else if (r < 55) c.op = FUNC_READ_POINT;
    else c.op = FUNC_READ_DIST;
    return c;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic send_cmd(cmd_t c, bit typed, beat_t want, bit may_idle);
    beat_t predicted;
    int    gap;
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= c.op;
    index_a  <= c.ia;
    index_b  <= c.ib;
    coord_x  <= c.cx;
    coord_y  <= c.cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_command(c);
    expected_beats.push_back(typed ? want : predicted);
  endtask

  // receiver stall bursts, switched off near the end
  initial begin
    int n;
    bit stall_now;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall_now = !quiet && ($urandom_range(0, 2) == 0);
      n = stall_now ? $urandom_range(1, 18) : $urandom_range(1, 60);
      repeat (n) begin
        @(negedge clk);
        out_stall <= stall_now && !quiet;
      end
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        note_failure($sformatf("unexpected beat: dist %0d x %0d y %0d",
                               distance_q8, point_x_out, point_y_out));
      end else begin
        want = expected_beats.pop_front();
        if (distance_q8 !== want.distance || point_x_out !== want.x ||
            point_y_out !== want.y)
          note_failure($sformatf(
            "mismatch: expected dist %0d x %0d y %0d, got dist %0d x %0d y %0d",
            want.distance, want.x, want.y, distance_q8, point_x_out, point_y_out));
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    cmd_t  c;
    beat_t none;
    int    k;
    none      = '0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    func      = FUNC_WRITE;
    index_a   = '0;
    index_b   = '0;
    coord_x   = '0;
    coord_y   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every point must hold a value before the first rebuild
    for (k = 3; k < NPTS - 1; k++) begin
      c.op = FUNC_WRITE;
      c.ia = IDX_IN_W'(k);
      c.ib = IDX_IN_W'($urandom);
      c.cx = COORD_W'($urandom);
      c.cy = COORD_W'($urandom);
      send_cmd(c, 1'b0, none, 1'b1);
    end

    // table reads zero until the first rebuild
    add_step(FUNC_READ_DIST,  0,  0,    0,    0, 1, 0, 0, 0);
    add_step(FUNC_READ_DIST, 63,  5, 1023, 1023, 1, 0, 0, 0);
    add_step(FUNC_WRITE,      0, 63,    0,    0, 1, 0, 0, 0);
    add_step(FUNC_WRITE,     63,  0, 1023, 1023, 1, 0, 0, 0);
    add_step(FUNC_WRITE,      1, 63, 1023,    0, 1, 0, 0, 0);
    add_step(FUNC_WRITE,      2,  0,    0, 1023, 1, 0, 0, 0);
    add_step(FUNC_READ_POINT, 63, 0,    0,    0, 1, 0, 1023, 1023);
    add_step(FUNC_READ_POINT, 0, 63, 1023, 1023, 1, 0, 0, 0);
    add_step(FUNC_READ_POINT, 1,  0,    0,    0, 1, 0, 1023, 0);
    add_step(FUNC_REBUILD,    0,  0,    0,    0, 1, 0, 0, 0);
    add_step(FUNC_READ_DIST,  0,  0,    0,    0, 1, DIAG_Q8, 0, 0);
    add_step(FUNC_READ_DIST, 63, 63, 1023, 1023, 1, DIAG_Q8, 0, 0);
    // axis-aligned full span is exactly 1023 in q8
    add_step(FUNC_READ_DIST,  0,  1,    0,    0, 1, 1023 << FRAC_SHIFT, 0, 0);
    add_step(FUNC_READ_DIST,  1,  0,    0,    0, 1, 1023 << FRAC_SHIFT, 0, 0);
    add_step(FUNC_READ_DIST,  0,  2,    0,    0, 1, 1023 << FRAC_SHIFT, 0, 0);
    add_step(FUNC_READ_DIST,  0, 63,    0,    0, 0, 0, 0, 0);
    add_step(FUNC_READ_DIST,  1,  2,    0,    0, 0, 0, 0, 0);
    add_step(FUNC_READ_DIST, 17, 40,    0,    0, 0, 0, 0, 0);
    // a point write must not touch the snapshot
    add_step(FUNC_WRITE,      0,  0,  512,  512, 1, 0, 0, 0);
    add_step(FUNC_READ_DIST,  0,  1,    0,    0, 1, 1023 << FRAC_SHIFT, 0, 0);
    add_step(FUNC_READ_POINT, 0,  0,    0,    0, 1, 0, 512, 512);
    foreach (directed_steps[i])
      send_cmd(directed_steps[i].cmd, directed_steps[i].typed, directed_steps[i].want, 1'b1);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (RANDOM_ITEMS - k <= QUIET_TAIL) quiet = 1'b1;
      send_cmd(random_cmd(k), 1'b0, none, ((k / 64) % 3) != 0);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
